// ===== rtl/core/qbsw_pkg.sv =====
// Shared types and constants for the queue buffer-state walk block.
`default_nettype none

package qbsw_pkg;

    localparam int unsigned BUF_IDX_W   = 7;
    localparam int unsigned STATE_W     = 8;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_QUEUES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_QUEUES = 2'd1;

    localparam logic [7:0] COUNT_LIMIT = 8'd128;
    localparam logic [7:0] BUF_IDX_MAX = 8'd127;

    localparam logic MODE_SET     = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] queue_index;
        logic [7:0] buffer_index;
        logic [7:0] buffer_count;
        logic [7:0] new_state;
    } t_in_beat;

    typedef struct packed {
        logic [6:0] next_buffer_index;
        logic [7:0] remaining_count;
        logic [7:0] extracted_state;
        logic       cond_code;
        logic       spec_exception;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIRST,
        ST_WALK,
        ST_DONE
    } t_walk_state;

endpackage : qbsw_pkg

`default_nettype wire

// ===== rtl/core/qbsw_store.sv =====
// Buffer-state byte memory: one write port, one read port, registered read data.
`default_nettype none

module qbsw_store #(
    parameter int unsigned DEPTH   = 8192,
    parameter int unsigned ADDR_W  = 13,
    parameter int unsigned DATA_W  = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule : qbsw_store

`default_nettype wire

// ===== rtl/core/queue_buffer_state_walk_core.sv =====
// Top level of the queue buffer-state walk: control sequencer, store and result register.
`default_nettype none

// The block keeps one state byte for each of 128 buffers of each of MAX_QUEUES
// queues in a single synchronous memory, and each input beat either sets or
// extracts a run of equal states starting at a queue and buffer index. After
// reset the block first clears the whole memory, one entry per cycle; during
// that pass the input is stalled, while configuration writes are taken as
// usual. An item with an invalid queue or buffer index goes straight to the
// done state, and its result is loaded into the output register from there.
// A valid item reads its starting entry and then walks the run until the
// count runs out or an entry differs from the first; an item with a zero
// count reads only its starting entry. The block takes the next beat only
// once the result is loaded and it is back in idle. The walk is paced by
// the memory: each cycle one entry's data returns, is compared with the first
// entry and, in set mode, overwritten with the new state, while the read of
// the following entry is issued. A finished result waits in an output
// register; the next item is accepted while it waits, and only the hand-over
// of a further result waits for it.
// Configuration must be written only while the block is idle.
module queue_buffer_state_walk_core #(
    parameter int unsigned MAX_QUEUES = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [qbsw_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [qbsw_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire qbsw_pkg::t_in_beat                  i_in,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output qbsw_pkg::t_out_beat                      o_out
);

    import qbsw_pkg::*;

    // The queue part of the address is as wide as the queue count needs.
    localparam int unsigned QW     = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
    localparam int unsigned AW     = QW + BUF_IDX_W;
    localparam int unsigned DEPTH  = MAX_QUEUES * (1 << BUF_IDX_W);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [8:0] QUEUE_LIMIT  = 9'(MAX_QUEUES);

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_in_queues;
    logic [CFG_DATA_W-1:0] r_out_queues;

    // Sequencer state and the item being walked.
    t_walk_state        r_state, n_state;
    logic [AW-1:0]      r_clr_addr, n_clr_addr;
    logic               r_mode, n_mode;
    logic [QW-1:0]      r_q, n_q;
    logic [6:0]         r_b, n_b;
    logic [7:0]         r_cnt, n_cnt;
    logic [7:0]         r_nstate, n_nstate;
    logic [7:0]         r_first, n_first;
    t_out_beat          r_res, n_res;

    // Output register.
    logic               r_out_valid;
    t_out_beat          r_out;
    logic               out_load;

    // Memory port signals.
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [7:0]         mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [7:0]         mem_rdata;

    // Decode of the incoming beat.
    logic [6:0]         queue_total;
    logic               in_bad;
    logic [7:0]         in_count;
    logic               in_accept;
    logic [6:0]         b_inc;
    logic [7:0]         cnt_dec;

    qbsw_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (AW),
        .DATA_W (STATE_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_queues  <= '0;
            r_out_queues <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INPUT_QUEUES:  r_in_queues  <= i_cfg_data;
                CFG_OUTPUT_QUEUES: r_out_queues <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A queue is valid below both the configured total and the store's size.
    assign queue_total = 7'(r_in_queues) + 7'(r_out_queues);
    assign in_bad      = (i_in.queue_index >= {1'b0, queue_total})
                      || ({1'b0, i_in.queue_index} >= QUEUE_LIMIT)
                      || (i_in.buffer_index > BUF_IDX_MAX);
    assign in_count    = (i_in.buffer_count > COUNT_LIMIT) ? COUNT_LIMIT
                                                           : i_in.buffer_count;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_load   = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

    assign b_inc   = r_b + 7'd1;
    assign cnt_dec = r_cnt - 8'd1;

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_mode     = r_mode;
        n_q        = r_q;
        n_b        = r_b;
        n_cnt      = r_cnt;
        n_nstate   = r_nstate;
        n_first    = r_first;
        n_res      = r_res;
        mem_we     = 1'b0;
        mem_waddr  = {r_q, r_b};
        mem_wdata  = r_nstate;
        // The next entry's read is issued while the current one is handled.
        mem_raddr  = {r_q, b_inc};

        case (r_state)
            ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                mem_raddr = {i_in.queue_index[QW-1:0], i_in.buffer_index[6:0]};
                if (in_accept) begin
                    n_mode   = i_in.mode;
                    n_q      = i_in.queue_index[QW-1:0];
                    n_b      = i_in.buffer_index[6:0];
                    n_cnt    = in_count;
                    n_nstate = i_in.new_state;
                    if (in_bad) begin
                        n_res                = '0;
                        n_res.spec_exception = 1'b1;
                        n_state              = ST_DONE;
                    end else begin
                        n_state = ST_FIRST;
                    end
                end
            end
            ST_FIRST: begin
                // The starting entry always belongs to the run.
                n_first = mem_rdata;
                n_res   = '0;
                n_res.extracted_state = mem_rdata;
                if (r_cnt == 8'd0) begin
                    n_res.next_buffer_index = r_b;
                    n_state = ST_DONE;
                end else begin
                    mem_we = (r_mode == MODE_SET);
                    n_b    = b_inc;
                    n_cnt  = cnt_dec;
                    if (cnt_dec == 8'd0) begin
                        n_res.next_buffer_index = b_inc;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (mem_rdata != r_first) begin
                    n_res.next_buffer_index = r_b;
                    n_res.remaining_count   = r_cnt;
                    n_res.cond_code         = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    mem_we = (r_mode == MODE_SET);
                    n_b    = b_inc;
                    n_cnt  = cnt_dec;
                    if (cnt_dec == 8'd0) begin
                        n_res.next_buffer_index = b_inc;
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_q      <= n_q;
        r_b      <= n_b;
        r_cnt    <= n_cnt;
        r_nstate <= n_nstate;
        r_first  <= n_first;
        r_res    <= n_res;
    end

    // The result register frees up in the cycle its beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A flagged result carries nothing else.
    a_spec_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.spec_exception) |->
            (o_out.next_buffer_index == 7'd0 && o_out.remaining_count == 8'd0
             && o_out.extracted_state == 8'd0 && !o_out.cond_code))
        else $error("flagged result carries nonzero fields");

    // The condition code mirrors whether any of the count is left.
    a_cond_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.cond_code == (o_out.remaining_count != 8'd0)))
        else $error("condition code does not match remaining count");

    // The walk never leaves more than the clamped count.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.remaining_count <= COUNT_LIMIT))
        else $error("remaining count above the clamp");

    // A result is only loaded from the done state.
    a_load_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result appeared outside the done state");

endmodule : queue_buffer_state_walk_core

`default_nettype wire
